FILE: hdl/bayer_quad_bin_to_rgb_defines.svh
// Assertion helpers for the Bayer quad binning block.
`ifndef BAYER_QUAD_BIN_TO_RGB_DEFINES_SVH
`define BAYER_QUAD_BIN_TO_RGB_DEFINES_SVH

// Same-cycle implication.
`define BQB_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bqb: same-cycle check failed");

// Next-cycle implication.
`define BQB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bqb: next-cycle check failed");

`endif

FILE: hdl/bqb_pkg.sv
package bqb_pkg;

  typedef struct packed {
    logic [15:0] raw_sample;
    logic        frame_start;
  } in_payload_t;

  typedef struct packed {
    logic [15:0] red_value;
    logic [15:0] green_value;
    logic [15:0] blue_value;
    logic        row_end;
    logic        config_error;
  } out_payload_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_payload_t;

  typedef enum logic [2:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_BLACK_LEVELS = 3'd1,
    REG_WHITE_LEVEL  = 3'd2,
    REG_OUTPUT_SCALE = 3'd3,
    REG_CFA_PATTERN  = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_RUN
  } div_state_e;

  localparam logic [12:0] RESET_LINE_WIDTH   = 13'd4096;
  localparam logic [63:0] RESET_BLACK_LEVELS = 64'd0;
  localparam logic [15:0] RESET_WHITE_LEVEL  = 16'd65535;
  localparam logic [15:0] RESET_OUTPUT_SCALE = 16'd256;
  localparam logic [7:0]  RESET_CFA_PATTERN  = 8'd228;

  localparam int unsigned DIV_STEPS = 32;

  localparam logic [31:0] RESET_GAIN =
    32'((64'(RESET_OUTPUT_SCALE) << 16) /
        (64'(RESET_WHITE_LEVEL) - 64'(RESET_BLACK_LEVELS[15:0])));

endpackage

FILE: hdl/bqb_stream_if.sv
interface bqb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/bayer_quad_bin_to_rgb.sv
// Bayer 2x2 binning to RGB.
// sample_i: raw samples in raster order, frame_start on the first sample of a frame.
// pixel_o:  one RGB pixel per 2x2 quad, 1.0 = 16*output_scale, saturating at 65535;
//           row_end on the last pixel of a row; config_error results on frame_start
//           while the pattern is not a permutation or the width is below two.
// cfg_i:    register writes (index, data); index above 4 is ignored.
// Throughput: one sample per cycle. The first row of a pair goes into a line RAM
// (MAX_WIDTH x 16, one write port, two registered read ports); second-row samples
// read the upper pair of the quad on even columns.
// Registers from the accepting edge of the odd second-row sample (or the
// error frame_start) to pixel_o.valid: quad register, black subtract, gain multiply,
// channel select/saturate output register. Each stage moves on when the next one is
// empty or moving, so samples keep flowing while a result waits at the output.
// Writing black_levels, white_level or output_scale recomputes the four gains with a
// serial restoring divider; while it runs, sample_i and cfg_i are not ready.
// Reset loads the default registers and their gains directly; no clearing pass.
// When the receiver stalls, results back up through the stages and sample_i.ready
// drops once the quad register is full.
`include "bayer_quad_bin_to_rgb_defines.svh"

module bayer_quad_bin_to_rgb #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bqb_stream_if.sink   sample_i,
  bqb_stream_if.source pixel_o,
  bqb_stream_if.sink   cfg_i
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = (AW + 2 > 13) ? AW + 2 : 13;

  // configuration registers
  logic [12:0] line_width_q;
  logic [63:0] black_levels_q;
  logic [15:0] white_level_q;
  logic [15:0] output_scale_q;
  logic [7:0]  cfa_pattern_q;
  logic [3:0][31:0] gain_q;

  // gain divider
  bqb_pkg::div_state_e div_state_q, div_state_d;
  logic [1:0]  div_pos_q, div_pos_d;
  logic [4:0]  div_step_q, div_step_d;
  logic [31:0] div_num_q, div_num_d;
  logic [15:0] div_rem_q, div_rem_d;
  logic [15:0] div_den_q, div_den_d;
  logic        gain_we;
  logic        div_busy;
  logic [16:0] range_diff;
  logic [15:0] range_sel;
  logic [16:0] rem_sh;

  logic cfg_acc;
  logic cfg_gain_write;

  assign div_busy = (div_state_q != bqb_pkg::DIV_IDLE);
  assign cfg_i.ready = !div_busy;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign cfg_gain_write = cfg_acc &&
    (cfg_i.data.index == bqb_pkg::REG_BLACK_LEVELS ||
     cfg_i.data.index == bqb_pkg::REG_WHITE_LEVEL ||
     cfg_i.data.index == bqb_pkg::REG_OUTPUT_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= bqb_pkg::RESET_LINE_WIDTH;
      black_levels_q <= bqb_pkg::RESET_BLACK_LEVELS;
      white_level_q  <= bqb_pkg::RESET_WHITE_LEVEL;
      output_scale_q <= bqb_pkg::RESET_OUTPUT_SCALE;
      cfa_pattern_q  <= bqb_pkg::RESET_CFA_PATTERN;
    end else if (cfg_acc) begin
      unique case (cfg_i.data.index)
        bqb_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_i.data.data[12:0];
        bqb_pkg::REG_BLACK_LEVELS: black_levels_q <= cfg_i.data.data;
        bqb_pkg::REG_WHITE_LEVEL:  white_level_q  <= cfg_i.data.data[15:0];
        bqb_pkg::REG_OUTPUT_SCALE: output_scale_q <= cfg_i.data.data[15:0];
        bqb_pkg::REG_CFA_PATTERN:  cfa_pattern_q  <= cfg_i.data.data[7:0];
        default: ;
      endcase
    end
  end

  // range = max(white - black, 1)
  always_comb begin
    range_diff = {1'b0, white_level_q} - {1'b0, black_levels_q[16*div_pos_q +: 16]};
    if (range_diff[16] || range_diff[15:0] == 16'd0) begin
      range_sel = 16'd1;
    end else begin
      range_sel = range_diff[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= bqb_pkg::DIV_IDLE;
      div_pos_q   <= 2'd0;
      div_step_q  <= 5'd0;
    end else begin
      div_state_q <= div_state_d;
      div_pos_q   <= div_pos_d;
      div_step_q  <= div_step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
  end

  always_comb begin
    div_state_d = div_state_q;
    div_pos_d   = div_pos_q;
    div_step_d  = div_step_q;
    div_num_d   = div_num_q;
    div_rem_d   = div_rem_q;
    div_den_d   = div_den_q;
    gain_we     = 1'b0;
    rem_sh      = {div_rem_q, div_num_q[31]};
    unique case (div_state_q)
      bqb_pkg::DIV_IDLE: begin
        if (cfg_gain_write) begin
          div_state_d = bqb_pkg::DIV_LOAD;
          div_pos_d   = 2'd0;
        end
      end
      bqb_pkg::DIV_LOAD: begin
        div_num_d   = {output_scale_q, 16'd0};
        div_rem_d   = 16'd0;
        div_den_d   = range_sel;
        div_step_d  = 5'd0;
        div_state_d = bqb_pkg::DIV_RUN;
      end
      bqb_pkg::DIV_RUN: begin
        if (rem_sh >= {1'b0, div_den_q}) begin
          div_rem_d = 16'(rem_sh - {1'b0, div_den_q});
          div_num_d = {div_num_q[30:0], 1'b1};
        end else begin
          div_rem_d = rem_sh[15:0];
          div_num_d = {div_num_q[30:0], 1'b0};
        end
        div_step_d = div_step_q + 5'd1;
        if (div_step_q == 5'(bqb_pkg::DIV_STEPS - 1)) begin
          gain_we = 1'b1;
          if (div_pos_q == 2'd3) begin
            div_state_d = bqb_pkg::DIV_IDLE;
          end else begin
            div_pos_d   = div_pos_q + 2'd1;
            div_state_d = bqb_pkg::DIV_LOAD;
          end
        end
      end
      default: div_state_d = bqb_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= {4{bqb_pkg::RESET_GAIN}};
    end else if (gain_we) begin
      gain_q[div_pos_q] <= div_num_d;
    end
  end

  // position tracking
  logic [AW-1:0] col_q, col_d, col_cur;
  logic          row2_q, row2_d, row2_cur;
  logic [15:0]   left_q;
  logic [WW-1:0] eff_w;
  logic [3:0]    seen;
  logic          cfg_ok;
  logic          in_acc, in_fs;
  logic [15:0]   in_raw;
  logic          mem_we, mem_re, emit, emit_err, emit_end;
  logic          rdy_s1, rdy_s2, rdy_s3, rdy_out;

  always_comb begin
    if (WW'(line_width_q) < WW'(MAX_WIDTH)) begin
      eff_w = WW'(line_width_q);
    end else begin
      eff_w = WW'(MAX_WIDTH);
    end
    seen = 4'd0;
    for (int i = 0; i < 4; i++) begin
      seen[cfa_pattern_q[2*i +: 2]] = 1'b1;
    end
    cfg_ok = (&seen) && (eff_w >= WW'(2));
  end

  assign sample_i.ready = rdy_s1 && !div_busy;
  assign in_acc = sample_i.valid && sample_i.ready;
  assign in_fs  = sample_i.data.frame_start;
  assign in_raw = sample_i.data.raw_sample;

  always_comb begin
    col_cur  = in_fs ? '0 : col_q;
    row2_cur = in_fs ? 1'b0 : row2_q;
    col_d    = col_q;
    row2_d   = row2_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    emit     = 1'b0;
    emit_err = 1'b0;
    emit_end = (WW'(col_cur) + WW'(2)) >= eff_w;
    if (in_acc) begin
      if (!cfg_ok) begin
        if (in_fs) begin
          col_d    = '0;
          row2_d   = 1'b0;
          emit     = 1'b1;
          emit_err = 1'b1;
        end
      end else begin
        if (!row2_cur) begin
          mem_we = 1'b1;
        end else if (!col_cur[0]) begin
          mem_re = 1'b1;
        end else begin
          emit = 1'b1;
        end
        if ((WW'(col_cur) + WW'(1)) >= eff_w) begin
          col_d  = '0;
          row2_d = !row2_cur;
        end else begin
          col_d = col_cur + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row2_q <= 1'b0;
      left_q <= 16'd0;
    end else begin
      col_q  <= col_d;
      row2_q <= row2_d;
      if (mem_re) begin
        left_q <= in_raw;
      end
    end
  end

  // line RAM
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] rd0_q, rd1_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[col_cur] <= in_raw;
    end
    if (mem_re) begin
      rd0_q <= line_mem[col_cur];
      rd1_q <= line_mem[col_cur + AW'(1)];
    end
  end

  // stage 1: quad
  logic             s1_v_q, s1_err_q, s1_end_q;
  logic [3:0][15:0] s1_q;
  // stage 2: black subtracted
  logic             s2_v_q, s2_err_q, s2_end_q;
  logic [3:0][15:0] s2_q;
  // stage 3: normalized
  logic             s3_v_q, s3_err_q, s3_end_q;
  logic [3:0][35:0] s3_q;
  // output
  logic                  out_v_q;
  bqb_pkg::out_payload_t out_q;

  assign rdy_out = !out_v_q || pixel_o.ready;
  assign rdy_s3  = !s3_v_q || rdy_out;
  assign rdy_s2  = !s2_v_q || rdy_s3;
  assign rdy_s1  = !s1_v_q || rdy_s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy_s1) begin
        s1_v_q <= emit;
      end
      if (rdy_s2) begin
        s2_v_q <= s1_v_q;
      end
      if (rdy_s3) begin
        s3_v_q <= s2_v_q;
      end
      if (rdy_out) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  logic [3:0][15:0] sub_d;
  logic [3:0][35:0] norm_d;
  logic [47:0]      prod [4];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      if (s1_q[p] > black_levels_q[16*p +: 16]) begin
        sub_d[p] = s1_q[p] - black_levels_q[16*p +: 16];
      end else begin
        sub_d[p] = 16'd0;
      end
      prod[p]   = {32'd0, s2_q[p]} * {16'd0, gain_q[p]};
      norm_d[p] = prod[p][47:12];
    end
  end

  function automatic logic [35:0] pick(input logic [3:0][35:0] v, input logic [1:0] sel);
    logic [35:0] r;
    unique case (sel)
      2'd0:    r = v[0];
      2'd1:    r = v[1];
      2'd2:    r = v[2];
      default: r = v[3];
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic [35:0] v);
    return (|v[35:16]) ? 16'hFFFF : v[15:0];
  endfunction

  logic [35:0] v_r, v_g0, v_g1, v_b;
  logic [36:0] g_sum;

  always_comb begin
    v_r   = pick(s3_q, cfa_pattern_q[1:0]);
    v_g0  = pick(s3_q, cfa_pattern_q[3:2]);
    v_g1  = pick(s3_q, cfa_pattern_q[5:4]);
    v_b   = pick(s3_q, cfa_pattern_q[7:6]);
    g_sum = {1'b0, v_g0} + {1'b0, v_g1};
  end

  always_ff @(posedge clk_i) begin
    if (rdy_s1 && emit) begin
      s1_err_q <= emit_err;
      s1_end_q <= emit_end;
      s1_q     <= {in_raw, left_q, rd1_q, rd0_q};
    end
    if (rdy_s2 && s1_v_q) begin
      s2_err_q <= s1_err_q;
      s2_end_q <= s1_end_q;
      s2_q     <= sub_d;
    end
    if (rdy_s3 && s2_v_q) begin
      s3_err_q <= s2_err_q;
      s3_end_q <= s2_end_q;
      s3_q     <= norm_d;
    end
    if (rdy_out && s3_v_q) begin
      if (s3_err_q) begin
        out_q.red_value    <= 16'd0;
        out_q.green_value  <= 16'd0;
        out_q.blue_value   <= 16'd0;
        out_q.row_end      <= 1'b0;
        out_q.config_error <= 1'b1;
      end else begin
        out_q.red_value    <= sat16(v_r);
        out_q.green_value  <= sat16(g_sum[36:1]);
        out_q.blue_value   <= sat16(v_b);
        out_q.row_end      <= s3_end_q;
        out_q.config_error <= 1'b0;
      end
    end
  end

  assign pixel_o.valid = out_v_q;
  assign pixel_o.data  = out_q;

  `BQB_ASSERT_NEXT(a_gain_write_starts_div, clk_i, rst_ni, cfg_gain_write, div_state_q == bqb_pkg::DIV_LOAD)
  `BQB_ASSERT_NEXT(a_div_ends_after_last, clk_i, rst_ni, div_state_q == bqb_pkg::DIV_RUN && div_pos_q == 2'd3 && div_step_q == 5'(bqb_pkg::DIV_STEPS - 1), div_state_q == bqb_pkg::DIV_IDLE)
  `BQB_ASSERT_IMPLIES(a_error_pixel_blank, clk_i, rst_ni, pixel_o.valid && pixel_o.data.config_error, pixel_o.data.red_value == 16'd0 && pixel_o.data.green_value == 16'd0 && pixel_o.data.blue_value == 16'd0 && !pixel_o.data.row_end)

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bqb_pkg::*;

  localparam int unsigned MAX_W = 4096;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam logic [2:0] REG_IDX_SPARE = 3'(REG_CFA_PATTERN) + 3'd1;

  typedef struct {
    bit           on;
    out_payload_t px;
  } listed_px_t;

  typedef struct {
    bit           is_reg;
    logic [2:0]   idx;
    logic [63:0]  value;
    in_payload_t  smp;
    bit           pinned;
    out_payload_t px;
  } step_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         smp_vld = 1'b0;
  in_payload_t  smp_dat = '0;
  logic         cfg_vld = 1'b0;
  cfg_payload_t cfg_dat = '0;
  logic         pix_rdy = 1'b0;

  bqb_stream_if #(.payload_t(in_payload_t))  sample_if ();
  bqb_stream_if #(.payload_t(out_payload_t)) pixel_if ();
  bqb_stream_if #(.payload_t(cfg_payload_t)) cfg_if ();

  assign sample_if.valid = smp_vld;
  assign sample_if.data  = smp_dat;
  assign cfg_if.valid    = cfg_vld;
  assign cfg_if.data     = cfg_dat;
  assign pixel_if.ready  = pix_rdy;

  bayer_quad_bin_to_rgb uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_if),
    .pixel_o  (pixel_if),
    .cfg_i    (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Binning predictor: registers, gains and position state
  logic [12:0] reg_width;
  logic [63:0] reg_black;
  logic [15:0] reg_white;
  logic [15:0] reg_scale;
  logic [7:0]  reg_cfa;
  logic [31:0] bin_gain [4];
  bit   [15:0] bin_rows [MAX_W];
  int unsigned bin_col;
  bit          bin_lower;
  logic [15:0] bin_left;

  out_payload_t pixels_due[$];
  listed_px_t   listed_pixels[$];
  step_t        plan[$];

  int n_sent, n_random, n_writes, n_pixels, n_err_px, n_bad;
  int burst_left;
  int stall_left, stall_max, mode_left;
  int quiet;

  function automatic void refresh_gains();
    int span;
    for (int p = 0; p < 4; p++) begin
      span = int'(reg_white) - int'(reg_black[16*p +: 16]);
      if (span < 1) span = 1;
      bin_gain[p] = 32'((longint'(reg_scale) << 16) / longint'(span));
    end
  endfunction

  function automatic void model_reset();
    reg_width = RESET_LINE_WIDTH;
    reg_black = RESET_BLACK_LEVELS;
    reg_white = RESET_WHITE_LEVEL;
    reg_scale = RESET_OUTPUT_SCALE;
    reg_cfa   = RESET_CFA_PATTERN;
    bin_col   = 0;
    bin_lower = 1'b0;
    bin_left  = '0;
    refresh_gains();
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] value);
    case (idx)
      REG_LINE_WIDTH: reg_width = value[12:0];
      REG_BLACK_LEVELS: begin
        reg_black = value;
        refresh_gains();
      end
      REG_WHITE_LEVEL: begin
        reg_white = value[15:0];
        refresh_gains();
      end
      REG_OUTPUT_SCALE: begin
        reg_scale = value[15:0];
        refresh_gains();
      end
      REG_CFA_PATTERN: reg_cfa = value[7:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned model_width();
    return (reg_width > MAX_W) ? MAX_W : int'(reg_width);
  endfunction

  function automatic bit model_cfg_ok();
    logic [3:0] seen;
    seen = '0;
    for (int i = 0; i < 4; i++) seen[reg_cfa[2*i +: 2]] = 1'b1;
    return (seen == 4'hF) && (model_width() >= 2);
  endfunction

  function automatic longint unsigned scaled(int p, logic [15:0] raw);
    logic [15:0]     floor_lvl;
    longint unsigned d;
    floor_lvl = reg_black[16*p +: 16];
    d = (raw > floor_lvl) ? longint'(raw - floor_lvl) : 0;
    return (d * bin_gain[p]) >> 12;
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic bit bin_step(in_payload_t s, output out_payload_t px);
    int unsigned     w, col;
    logic [15:0]     quad [4];
    longint unsigned lvl [4];
    bit              made;
    px = '0;
    made = 1'b0;
    if (s.frame_start) begin
      bin_col = 0;
      bin_lower = 1'b0;
    end
    if (!model_cfg_ok()) begin
      px.config_error = s.frame_start;
      return s.frame_start;
    end
    w = model_width();
    col = bin_col;
    if (col >= MAX_W) col = MAX_W - 1;
    if (!bin_lower) begin
      bin_rows[col] = s.raw_sample;
    end else if (!col[0]) begin
      bin_left = s.raw_sample;
    end else begin
      quad[0] = bin_rows[col - 1];
      quad[1] = bin_rows[col];
      quad[2] = bin_left;
      quad[3] = s.raw_sample;
      for (int p = 0; p < 4; p++) lvl[p] = scaled(p, quad[p]);
      px.red_value   = clip16(lvl[reg_cfa[1:0]]);
      px.green_value = clip16((lvl[reg_cfa[3:2]] + lvl[reg_cfa[5:4]]) >> 1);
      px.blue_value  = clip16(lvl[reg_cfa[7:6]]);
      px.row_end     = (col + 2 >= w);
      made = 1'b1;
    end
    if (col + 1 >= w) begin
      bin_col = 0;
      bin_lower = !bin_lower;
    end else begin
      bin_col = col + 1;
    end
    return made;
  endfunction

  // Monitor: feeds the predictor on every accepted request, checks pixels in order
  always @(posedge clk) begin : watch
    out_payload_t want, made;
    listed_px_t   pin;
    bit           hit;
    if (rst_n) begin
      if (pixel_if.valid && pixel_if.ready) begin
        n_pixels++;
        if (pixel_if.data.config_error) n_err_px++;
        if (pixels_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("%0t: pixel arrived with nothing pending", $realtime);
        end else begin
          want = pixels_due.pop_front();
          if (pixel_if.data.red_value !== want.red_value ||
              pixel_if.data.green_value !== want.green_value ||
              pixel_if.data.blue_value !== want.blue_value ||
              pixel_if.data.row_end !== want.row_end ||
              pixel_if.data.config_error !== want.config_error) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: pixel mismatch: want r=%0d g=%0d b=%0d end=%0b err=%0b, got r=%0d g=%0d b=%0d end=%0b err=%0b",
                       $realtime, want.red_value, want.green_value, want.blue_value,
                       want.row_end, want.config_error, pixel_if.data.red_value,
                       pixel_if.data.green_value, pixel_if.data.blue_value,
                       pixel_if.data.row_end, pixel_if.data.config_error);
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.data.index, cfg_if.data.data);
      if (sample_if.valid && sample_if.ready) begin
        n_sent++;
        pin = listed_pixels.pop_front();
        hit = bin_step(sample_if.data, made);
        if (pin.on) pixels_due.push_back(pin.px);
        else if (hit) pixels_due.push_back(made);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((sample_if.valid && sample_if.ready) || (pixel_if.valid && pixel_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $realtime, quiet);
        $display("bayer_quad_bin_to_rgb regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts whose maximum length is redrawn each time mode_left runs out
  always @(posedge clk) begin
    if (stall_left > 0) begin
      pix_rdy <= 1'b0;
      stall_left--;
    end else begin
      pix_rdy <= 1'b1;
      if (stall_max > 0 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, stall_max);
    end
    if (mode_left <= 0) begin
      case ($urandom_range(0, 3))
        0: stall_max = 0;
        1: stall_max = 2;
        2: stall_max = 6;
        default: stall_max = 40;
      endcase
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
  end

  task automatic send_sample(in_payload_t s, bit pinned = 1'b0, out_payload_t px = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        smp_vld <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 48);
    end
    listed_pixels.push_back('{pinned, px});
    smp_vld <= 1'b1;
    smp_dat <= s;
    do @(posedge clk); while (!sample_if.ready);
    burst_left--;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_vld <= 1'b1;
    cfg_dat <= '{index: idx, data: value};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_vld <= 1'b0;
    n_writes++;
    @(posedge clk);
  endtask

  // Hold the sample side until every pending pixel is out and the stages are empty
  task automatic settle();
    smp_vld <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pixels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      1, 2: return 16'($urandom_range(0, 8191));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_payload_t make_sample(bit fs);
    in_payload_t s;
    s.raw_sample = pick_raw();
    s.frame_start = fs;
    return s;
  endfunction

  function automatic logic [63:0] pick_value(logic [2:0] idx);
    logic [63:0] v;
    logic [1:0]  perm [4];
    logic [1:0]  t;
    int          j;
    v = '0;
    case (idx)
      REG_LINE_WIDTH: begin
        case ($urandom_range(0, 15))
          0: v = $urandom_range(0, 1);
          1: v = $urandom_range(65, 300);
          default: v = $urandom_range(2, 24);
        endcase
      end
      REG_BLACK_LEVELS: begin
        for (int p = 0; p < 4; p++)
          v[16*p +: 16] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
      end
      REG_WHITE_LEVEL: begin
        case ($urandom_range(0, 7))
          0: v = 16'($urandom);
          1: v = 16'hFFFF;
          default: v = $urandom_range(20000, 65535);
        endcase
      end
      REG_OUTPUT_SCALE: begin
        case ($urandom_range(0, 9))
          0: v = 0;
          1: v = 16'hFFFF;
          2, 3: v = 16'($urandom);
          default: v = $urandom_range(128, 1024);
        endcase
      end
      REG_CFA_PATTERN: begin
        if ($urandom_range(0, 9) == 0) begin
          v = 8'($urandom);
        end else begin
          for (int i = 0; i < 4; i++) perm[i] = 2'(i);
          for (int i = 3; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
          end
          v = {perm[3], perm[2], perm[1], perm[0]};
        end
      end
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic run_phase();
    logic [2:0]  idx;
    int unsigned w;
    int          rows;
    bit          fresh, fs;
    settle();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 19) == 0) idx = REG_IDX_SPARE + 3'($urandom_range(0, 2));
      else idx = 3'($urandom_range(REG_LINE_WIDTH, REG_CFA_PATTERN));
      write_reg(idx, pick_value(idx));
    end
    for (int f = 0; f < $urandom_range(1, 3); f++) begin
      if (!model_cfg_ok()) begin
        send_sample(make_sample(1'b1));
        repeat ($urandom_range(0, 3)) send_sample(make_sample(1'b0));
        continue;
      end
      w = model_width();
      rows = (w > 64) ? 2 : $urandom_range(1, 5);
      // now and then pick up mid-frame from where the previous setting left off
      fresh = !(f == 0 && $urandom_range(0, 3) == 0);
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < w; c++) begin
          fs = (fresh && r == 0 && c == 0) || ($urandom_range(0, 149) == 0);
          send_sample(make_sample(fs));
          n_random++;
        end
      end
    end
  endtask

  function automatic out_payload_t pix(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                       logic re, logic err);
    return '{red_value: r, green_value: g, blue_value: b, row_end: re, config_error: err};
  endfunction

  function automatic void plan_reg(logic [2:0] idx, logic [63:0] value);
    step_t st;
    st.is_reg = 1'b1;
    st.idx    = idx;
    st.value  = value;
    st.smp    = '0;
    st.pinned = 1'b0;
    st.px     = '0;
    plan.push_back(st);
  endfunction

  function automatic void plan_smp(logic [15:0] raw, bit fs, bit pinned = 1'b0,
                                   out_payload_t px = '0);
    step_t st;
    st.is_reg = 1'b0;
    st.idx    = '0;
    st.value  = '0;
    st.smp    = '{raw_sample: raw, frame_start: fs};
    st.pinned = pinned;
    st.px     = px;
    plan.push_back(st);
  endfunction

  function automatic void load_plan();
    // full scale and a ramp under the reset gains
    plan_reg(REG_LINE_WIDTH, 2);
    plan_smp(16'hFFFF, 1);
    plan_smp(16'hFFFF, 0);
    plan_smp(16'hFFFF, 0);
    plan_smp(16'hFFFF, 0, 1, pix(4095, 4095, 4095, 1, 0));
    plan_smp(16, 1);
    plan_smp(32, 0);
    plan_smp(48, 0);
    plan_smp(64, 0, 1, pix(1, 2, 4, 1, 0));
    // largest gain saturates every channel
    plan_reg(REG_OUTPUT_SCALE, 16'hFFFF);
    plan_reg(REG_WHITE_LEVEL, 1);
    plan_smp(1, 1);
    plan_smp(1, 0);
    plan_smp(1, 0);
    plan_smp(1, 0, 1, pix(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0));
    // black above white: range clamps, samples clamp at zero
    plan_reg(REG_BLACK_LEVELS, '1);
    plan_smp(16'hFFFF, 1);
    plan_smp(16'hFFFF, 0);
    plan_smp(16'hFFFF, 0);
    plan_smp(16'hFFFF, 0, 1, pix(0, 0, 0, 1, 0));
    // pattern not a permutation, then widths below two
    plan_reg(REG_CFA_PATTERN, 0);
    plan_smp(16'h8001, 1, 1, pix(0, 0, 0, 0, 1));
    plan_smp(16'h7FFE, 0);
    plan_reg(REG_CFA_PATTERN, RESET_CFA_PATTERN);
    plan_reg(REG_LINE_WIDTH, 1);
    plan_smp(16'h5555, 1, 1, pix(0, 0, 0, 0, 1));
    plan_reg(REG_LINE_WIDTH, 0);
    plan_smp(16'hAAAA, 1, 1, pix(0, 0, 0, 0, 1));
    // odd width, odd row count, swapped pattern, ignored index
    plan_reg(REG_BLACK_LEVELS, RESET_BLACK_LEVELS);
    plan_reg(REG_WHITE_LEVEL, RESET_WHITE_LEVEL);
    plan_reg(REG_OUTPUT_SCALE, RESET_OUTPUT_SCALE);
    plan_reg(REG_LINE_WIDTH, 3);
    plan_reg(REG_CFA_PATTERN, 8'h1B);
    plan_smp(16'h1000, 1);
    plan_smp(16'h2000, 0);
    plan_smp(16'hF00F, 0);
    plan_smp(16'h3000, 0);
    plan_smp(16'h4000, 0);
    plan_smp(16'h0F0F, 0);
    plan_smp(16'h1234, 0);
    plan_smp(16'h4321, 1);
    plan_reg(REG_IDX_SPARE, '1);
  endfunction

  initial begin
    model_reset();
    burst_left = 0;
    stall_left = 0;
    stall_max = 0;
    mode_left = 0;
    quiet = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_plan();
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_sample(plan[i].smp, plan[i].pinned, plan[i].px);
      end
    end

    // one full-width row pair; width above the store size clamps to it
    settle();
    write_reg(REG_LINE_WIDTH, 64'h1FFF);
    for (int c = 0; c < 2 * model_width(); c++) send_sample(make_sample(c == 0));

    while (n_random < RANDOM_ITEMS) run_phase();

    settle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    n_bad += pixels_due.size();

    $display("run covered %0d raw samples (%0d random) and %0d register writes",
             n_sent, n_random, n_writes);
    $display("checked %0d pixels, %0d of them error results, %0d mismatches",
             n_pixels, n_err_px, n_bad);
    if (n_bad == 0) begin
      $display("bayer_quad_bin_to_rgb regression: pass");
    end else begin
      $display("bayer_quad_bin_to_rgb regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bqb_pkg.sv
hdl/bqb_stream_if.sv
hdl/bayer_quad_bin_to_rgb.sv
dv/testbench.sv
